// ===== rtl/core/lpt_pkg.sv =====
// Shared types and constants for the LRU page time-stamp tracker.
package lpt_pkg;

    // Fixed field widths of the command and result beats.
    localparam int OP_W     = 3;
    localparam int COUNT_W  = 6;
    localparam int ADDR_W   = 32;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 2;

    // Operation codes; the codes above OP_VICTIM are unused.
    typedef enum logic [OP_W-1:0] {
        OP_TRACK   = 3'd0,
        OP_UNTRACK = 3'd1,
        OP_TICK    = 3'd2,
        OP_TOUCH   = 3'd3,
        OP_VICTIM  = 3'd4
    } t_op;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_FINISH,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_op;
        logic clear;
        logic issue;
        logic finish;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_last;
    } t_dp_stat;

endpackage

// ===== rtl/core/lpt_ctrl.sv =====
// Controller state machine of the LRU page time-stamp tracker.
module lpt_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [lpt_pkg::OP_W-1:0]    i_operation,
    input  lpt_pkg::t_dp_stat           i_stat,
    output lpt_pkg::t_dp_cmd            o_cmd,
    output logic                        busy
);

    lpt_pkg::t_state r_state;
    lpt_pkg::t_state n_state;

    // State register; reset starts the clearing pass over the slot memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpt_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lpt_pkg::S_CLEAR: begin
                if (i_stat.idx_last) begin
                    n_state = lpt_pkg::S_IDLE;
                end
            end
            lpt_pkg::S_IDLE: begin
                if (start) begin
                    case (lpt_pkg::t_op'(i_operation))
                        lpt_pkg::OP_TRACK,
                        lpt_pkg::OP_UNTRACK,
                        lpt_pkg::OP_TOUCH,
                        lpt_pkg::OP_VICTIM: n_state = lpt_pkg::S_SCAN;
                        default:            n_state = lpt_pkg::S_FINISH;
                    endcase
                end
            end
            lpt_pkg::S_SCAN: begin
                if (i_stat.idx_last) begin
                    n_state = lpt_pkg::S_WAIT;
                end
            end
            lpt_pkg::S_WAIT:   n_state = lpt_pkg::S_FINISH;
            lpt_pkg::S_FINISH: n_state = lpt_pkg::S_EMIT;
            lpt_pkg::S_EMIT:   n_state = lpt_pkg::S_IDLE;
            default:           n_state = lpt_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            lpt_pkg::S_CLEAR:  o_cmd.clear = 1'b1;
            lpt_pkg::S_IDLE: begin
                busy         = 1'b0;
                o_cmd.start_op = start;
            end
            lpt_pkg::S_SCAN:   o_cmd.issue  = 1'b1;
            lpt_pkg::S_WAIT:   o_cmd        = '0;
            lpt_pkg::S_FINISH: o_cmd.finish = 1'b1;
            lpt_pkg::S_EMIT:   o_cmd.emit   = 1'b1;
            default:           o_cmd        = '0;
        endcase
    end

endmodule

// ===== rtl/core/lpt_dp.sv =====
// Datapath of the LRU page time-stamp tracker: slot memory, scan stage and result.
module lpt_dp #(
    parameter int SLOTS           = 32,
    parameter int PAGE_BYTES      = 4096,
    parameter int PAGE_INDEX_BITS = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lpt_pkg::t_dp_cmd                i_cmd,
    output lpt_pkg::t_dp_stat               o_stat,
    input  logic                            i_cfg_wr_en,
    input  logic [lpt_pkg::ADDR_W-1:0]      i_cfg_wr_data,
    input  logic [lpt_pkg::OP_W-1:0]        i_operation,
    input  logic [PAGE_INDEX_BITS-1:0]      i_first_page,
    input  logic [lpt_pkg::COUNT_W-1:0]     i_page_count,
    output logic                            o_done,
    output logic [lpt_pkg::ADDR_W-1:0]      o_address,
    output logic [PAGE_INDEX_BITS-1:0]      o_victim_page,
    output logic [lpt_pkg::STATUS_W-1:0]    o_status
);

    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int PIB       = PAGE_INDEX_BITS;
    localparam int ENTRY_W   = 1 + PIB + lpt_pkg::STAMP_W;
    localparam int RUN_MAX   = 2 ** lpt_pkg::COUNT_W;
    localparam int VALID_BIT = ENTRY_W - 1;
    localparam int PAGE_LSB  = lpt_pkg::STAMP_W;

    // Slot memory: each word holds the valid flag, the page index and the stamp.
    logic [ENTRY_W-1:0]             r_mem [SLOTS];
    logic [ENTRY_W-1:0]             r_rd_data;
    logic                           mem_we;
    logic [SLOT_BITS-1:0]           mem_waddr;
    logic [ENTRY_W-1:0]             mem_wdata;

    // Scan position and compare stage.
    logic [SLOT_BITS-1:0]           r_idx;
    logic                           r_cmp_vld;
    logic [SLOT_BITS-1:0]           r_cmp_idx;

    // Latched command and per-operation accumulators.
    lpt_pkg::t_op                   r_op;
    logic [PIB-1:0]                 r_first;
    logic [lpt_pkg::COUNT_W-1:0]    r_count;
    logic                           r_has_addr;
    logic [lpt_pkg::COUNT_W-1:0]    r_placed;
    logic [RUN_MAX-1:0]             r_found;
    logic                           r_any;
    logic [lpt_pkg::STAMP_W-1:0]    r_oldest;
    logic [PIB-1:0]                 r_victim;

    // Architectural registers.
    logic [lpt_pkg::STAMP_W-1:0]    r_tick;
    logic [lpt_pkg::ADDR_W-1:0]     r_base;

    // Result path.
    logic [lpt_pkg::ADDR_W-1:0]     r_prod;
    logic [lpt_pkg::STATUS_W-1:0]   r_status_fin;
    logic                           r_strobe;
    logic [lpt_pkg::ADDR_W-1:0]     r_address;
    logic [PIB-1:0]                 r_victim_out;
    logic [lpt_pkg::STATUS_W-1:0]   r_status_out;

    // Compare stage decode.
    logic                           cmp_valid;
    logic [PIB-1:0]                 cmp_page;
    logic [lpt_pkg::STAMP_W-1:0]    cmp_stamp;
    logic [PIB-1:0]                 cmp_offset;
    logic                           cmp_in_run;
    logic                           cmp_we;
    logic [ENTRY_W-1:0]             cmp_wdata;
    logic [lpt_pkg::COUNT_W-1:0]    n_placed;
    logic [RUN_MAX-1:0]             n_found;
    logic                           n_any;
    logic [lpt_pkg::STAMP_W-1:0]    n_oldest;
    logic [PIB-1:0]                 n_victim;
    logic [RUN_MAX-1:0]             count_mask;
    logic [PIB-1:0]                 page_sel;

    assign o_stat.idx_last = (r_idx == SLOT_BITS'(SLOTS - 1));

    assign cmp_valid  = r_rd_data[VALID_BIT];
    assign cmp_page   = r_rd_data[PAGE_LSB +: PIB];
    assign cmp_stamp  = r_rd_data[lpt_pkg::STAMP_W-1:0];
    assign cmp_offset = cmp_page - r_first;
    assign cmp_in_run = cmp_valid && (cmp_offset < PIB'(r_count));

    // Compare stage: decide the write-back and update the accumulators for one slot.
    always_comb begin
        cmp_we    = 1'b0;
        cmp_wdata = r_rd_data;
        n_placed  = r_placed;
        n_found   = r_found;
        n_any     = r_any;
        n_oldest  = r_oldest;
        n_victim  = r_victim;
        if (r_cmp_vld) begin
            case (r_op)
                lpt_pkg::OP_TRACK: begin
                    if (!cmp_valid && (r_placed != r_count)) begin
                        cmp_we    = 1'b1;
                        cmp_wdata = {1'b1, r_first + PIB'(r_placed), r_tick};
                        n_placed  = r_placed + 1'b1;
                    end
                end
                lpt_pkg::OP_UNTRACK: begin
                    if (cmp_in_run && !r_found[cmp_offset[lpt_pkg::COUNT_W-1:0]]) begin
                        cmp_we    = 1'b1;
                        cmp_wdata = {1'b0, cmp_page, {lpt_pkg::STAMP_W{1'b0}}};
                        n_found[cmp_offset[lpt_pkg::COUNT_W-1:0]] = 1'b1;
                    end
                end
                lpt_pkg::OP_TOUCH: begin
                    if (cmp_valid && (cmp_page == r_first)) begin
                        cmp_we    = 1'b1;
                        cmp_wdata = {1'b1, cmp_page, r_tick};
                        n_any     = 1'b1;
                    end
                end
                lpt_pkg::OP_VICTIM: begin
                    if (cmp_valid && (cmp_stamp < r_oldest)) begin
                        n_oldest = cmp_stamp;
                        n_victim = cmp_page;
                    end
                end
                default: cmp_we = 1'b0;
            endcase
        end
    end

    // Memory write port: clearing pass or compare-stage write-back.
    always_comb begin
        if (i_cmd.clear) begin
            mem_we    = 1'b1;
            mem_waddr = r_idx;
            mem_wdata = '0;
        end else begin
            mem_we    = cmp_we;
            mem_waddr = r_cmp_idx;
            mem_wdata = cmp_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    // Registered read of the slot at the scan position.
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // Scan position and compare-stage tag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.issue;
            if (i_cmd.start_op) begin
                r_idx <= '0;
            end else if (i_cmd.clear || i_cmd.issue) begin
                r_idx <= o_stat.idx_last ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
    end

    // Base address register and the saturating tick counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_tick <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
            if (i_cmd.start_op && (lpt_pkg::t_op'(i_operation) == lpt_pkg::OP_TICK)
                    && (r_tick != {lpt_pkg::STAMP_W{1'b1}})) begin
                r_tick <= r_tick + 1'b1;
            end
        end
    end

    // Latch the command beat and initialise the accumulators.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_op) begin
            r_op       <= lpt_pkg::t_op'(i_operation);
            r_first    <= i_first_page;
            r_count    <= i_page_count;
            r_has_addr <= (lpt_pkg::t_op'(i_operation) == lpt_pkg::OP_TRACK)
                       || (lpt_pkg::t_op'(i_operation) == lpt_pkg::OP_UNTRACK)
                       || (lpt_pkg::t_op'(i_operation) == lpt_pkg::OP_TOUCH)
                       || (lpt_pkg::t_op'(i_operation) == lpt_pkg::OP_VICTIM);
            r_placed   <= '0;
            r_found    <= '0;
            r_any      <= 1'b0;
            r_oldest   <= r_tick;
            r_victim   <= '0;
        end else begin
            r_placed   <= n_placed;
            r_found    <= n_found;
            r_any      <= n_any;
            r_oldest   <= n_oldest;
            r_victim   <= n_victim;
        end
    end

    // Mask of the run offsets that untrack must have found.
    always_comb begin
        for (int k = 0; k < RUN_MAX; k++) begin
            count_mask[k] = (k < int'(r_count));
        end
    end

    assign page_sel = (r_op == lpt_pkg::OP_VICTIM) ? r_victim : r_first;

    // Finish: page times page size, and the final status.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_prod <= lpt_pkg::ADDR_W'(page_sel) * lpt_pkg::ADDR_W'(PAGE_BYTES);
            case (r_op)
                lpt_pkg::OP_TRACK:
                    r_status_fin <= (r_placed != r_count) ? lpt_pkg::STATUS_FULL
                                                          : lpt_pkg::STATUS_OK;
                lpt_pkg::OP_UNTRACK:
                    r_status_fin <= (r_found != count_mask) ? lpt_pkg::STATUS_NOT_FOUND
                                                            : lpt_pkg::STATUS_OK;
                lpt_pkg::OP_TOUCH:
                    r_status_fin <= r_any ? lpt_pkg::STATUS_OK
                                          : lpt_pkg::STATUS_NOT_FOUND;
                default:
                    r_status_fin <= lpt_pkg::STATUS_OK;
            endcase
        end
    end

    // Result beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_address    <= r_has_addr ? r_base + r_prod : '0;
            r_victim_out <= r_victim;
            r_status_out <= r_status_fin;
        end
    end

    assign o_done        = r_strobe;
    assign o_address     = r_address;
    assign o_victim_page = r_victim_out;
    assign o_status      = r_status_out;

endmodule

// ===== rtl/core/lru_page_timestamp_tracker.sv =====
// Top level of the LRU page time-stamp tracker.
//
// After reset the block sweeps its slot memory once, one slot a cycle, and busy stays high until
// the sweep is done; the base address may be written meanwhile. A command is taken when start is
// high and busy is low. Track, untrack, touch and victim each make one pass over the slot memory,
// one slot per cycle through its single read port, then go through the wait, finish and emit states
// before the result beat is registered; the next command can be taken in the same cycle as that
// result beat. Tick and unused codes skip the pass and go straight to the finish and emit states.
// Every command gives exactly one result beat, shown for one cycle with o_done high; the receiver
// must take it then.
module lru_page_timestamp_tracker #(
    parameter int SLOTS           = 32,
    parameter int PAGE_BYTES      = 4096,
    parameter int PAGE_INDEX_BITS = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [lpt_pkg::ADDR_W-1:0]      i_cfg_wr_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [lpt_pkg::OP_W-1:0]        i_operation,
    input  logic [PAGE_INDEX_BITS-1:0]      i_first_page,
    input  logic [lpt_pkg::COUNT_W-1:0]     i_page_count,
    output logic                            o_done,
    output logic [lpt_pkg::ADDR_W-1:0]      o_address,
    output logic [PAGE_INDEX_BITS-1:0]      o_victim_page,
    output logic [lpt_pkg::STATUS_W-1:0]    o_status
);

    lpt_pkg::t_dp_cmd  dp_cmd;
    lpt_pkg::t_dp_stat dp_stat;

    // Sequencer.
    lpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd),
        .busy        (busy)
    );

    // Slot memory and result path.
    lpt_dp #(
        .SLOTS           (SLOTS),
        .PAGE_BYTES      (PAGE_BYTES),
        .PAGE_INDEX_BITS (PAGE_INDEX_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_operation    (i_operation),
        .i_first_page   (i_first_page),
        .i_page_count   (i_page_count),
        .o_done         (o_done),
        .o_address      (o_address),
        .o_victim_page  (o_victim_page),
        .o_status       (o_status)
    );

    // A result beat is never followed directly by another one.
    a_done_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result beats back to back");

    // A command beat taken makes the block busy in the next cycle.
    a_busy_after_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command");

    // No result beat directly after a command is taken.
    a_no_done_on_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_done)
        else $error("result beat right after command");

    // Status is one of the defined codes on every result beat.
    a_status_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == lpt_pkg::STATUS_OK || o_status == lpt_pkg::STATUS_FULL
                    || o_status == lpt_pkg::STATUS_NOT_FOUND))
        else $error("undefined status code");

endmodule
